>>> rtl/dtp_pkg.sv
// Package for the depth-to-point back-projection block.
// Holds the payload structs, the controller/datapath command and status structs,
// the configuration constants and the shared helper functions. Depends on nothing.
`default_nettype none

package dtp_pkg;

    localparam int MAX_COLS   = 4096;
    localparam int MAX_ROWS   = 4096;
    localparam int CNT_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int DEPTH_W    = 16;
    localparam int RECIP_W    = 24;
    localparam int PRINC_W    = 16;
    localparam int Z_W        = 32;
    localparam int COORD_W    = 48;
    localparam int Q_W        = 44;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int M_W        = 48;
    localparam int M_HALF_W   = M_W / 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_DEPTH_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd6;

    localparam logic [RECIP_W-1:0] RST_INV_DEPTH_SCALE = 24'd16777;
    localparam logic [PRINC_W-1:0] RST_PRINCIPAL_X     = 16'd5120;
    localparam logic [PRINC_W-1:0] RST_PRINCIPAL_Y     = 16'd3840;
    localparam logic [RECIP_W-1:0] RST_INV_FOCAL_X     = 24'd32263;
    localparam logic [RECIP_W-1:0] RST_INV_FOCAL_Y     = 24'd32263;
    localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH     = 13'd640;
    localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT    = 13'd480;

    localparam logic [1:0] MS_DEPTH = 2'd0;
    localparam logic [1:0] MS_MAG   = 2'd1;
    localparam logic [1:0] MS_MLO   = 2'd2;
    localparam logic [1:0] MS_MHI   = 2'd3;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_sample;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [Z_W-1:0]            point_z;
        logic [7:0]                point_blue;
        logic [7:0]                point_green;
        logic [7:0]                point_red;
        logic                      point_valid;
        logic                      frame_end;
    } t_point;

    typedef struct packed {
        logic       load_in;
        logic [1:0] mul_sel;
        logic       axis;
        logic       cap_z;
        logic       cap_mhi;
        logic       cap_lo;
        logic       cap_q;
        logic       cap_x;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic depth_zero;
        logic frame_end;
        logic out_free;
    } t_dp_sts;

    // Frame size minus one, clamped to the range one to the maximum.
    function automatic logic [CNT_W-1:0] size_m1(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] vmax);
        logic [SIZE_W-1:0] t;
        if (v == '0) begin
            t = '0;
        end else if (v > vmax) begin
            t = vmax - SIZE_W'(1);
        end else begin
            t = v - SIZE_W'(1);
        end
        return t[CNT_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] apply_sign(input logic [Q_W-1:0] q,
                                                             input logic neg);
        logic [COORD_W-1:0] e;
        e = {{(COORD_W-Q_W){1'b0}}, q};
        return neg ? -e : e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/dtp_ctrl.sv
// Sequencing controller of the depth-to-point back-projection block.
// Steps the shared multiplier through depth, X and Y and issues commands to dtp_datapath.
// Depends on dtp_pkg.
`default_nettype none

module dtp_ctrl import dtp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_pix_valid,
    output logic         o_pix_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MZ   = 4'd1;
    localparam logic [3:0] ST_ZR   = 4'd2;
    localparam logic [3:0] ST_PM   = 4'd3;
    localparam logic [3:0] ST_PL   = 4'd4;
    localparam logic [3:0] ST_PH   = 4'd5;
    localparam logic [3:0] ST_PS   = 4'd6;
    localparam logic [3:0] ST_EMIT = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_axis;
    logic       n_axis;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.mul_sel = MS_DEPTH;
        o_cmd.axis    = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pix_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_MZ;
                end
            end
            ST_MZ: begin
                o_cmd.mul_sel = MS_DEPTH;
                if (i_sts.depth_zero) begin
                    n_state = i_sts.frame_end ? ST_EMIT : ST_IDLE;
                end else begin
                    n_state = ST_ZR;
                end
            end
            ST_ZR: begin
                o_cmd.cap_z = 1'b1;
                n_axis  = 1'b0;
                n_state = ST_PM;
            end
            ST_PM: begin
                o_cmd.mul_sel = MS_MAG;
                o_cmd.cap_x   = r_axis;
                n_state = ST_PL;
            end
            ST_PL: begin
                o_cmd.mul_sel = MS_MLO;
                o_cmd.cap_mhi = 1'b1;
                n_state = ST_PH;
            end
            ST_PH: begin
                o_cmd.mul_sel = MS_MHI;
                o_cmd.cap_lo  = 1'b1;
                n_state = ST_PS;
            end
            ST_PS: begin
                o_cmd.cap_q = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = ST_PM;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_pix_stall = (r_state != ST_IDLE);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !o_pix_stall) |=> (r_state == ST_MZ))
        else $error("An accepted transaction did not start the depth multiply.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("Output register loaded while it still held a transaction.");

endmodule

`default_nettype wire

>>> rtl/dtp_datapath.sv
// Datapath of the depth-to-point back-projection block: configuration registers,
// pixel counters, the shared 32x24 multiplier, rounding and the output register.
// Depends on dtp_pkg; driven by dtp_ctrl.
`default_nettype none

module dtp_datapath import dtp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  wire t_pixel                i_pix,
    output t_point                     o_pt,
    output logic                       o_pt_valid,
    input  wire logic                  i_pt_stall,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts
);

    logic [RECIP_W-1:0] r_inv_depth_scale;
    logic [PRINC_W-1:0] r_principal_x;
    logic [PRINC_W-1:0] r_principal_y;
    logic [RECIP_W-1:0] r_inv_focal_x;
    logic [RECIP_W-1:0] r_inv_focal_y;
    logic [SIZE_W-1:0]  r_frame_width;
    logic [SIZE_W-1:0]  r_frame_height;

    logic [CNT_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_row;

    t_pixel             r_pix;
    logic               r_fend;
    logic [PRINC_W-1:0] r_mag_x;
    logic [PRINC_W-1:0] r_mag_y;
    logic               r_neg_x;
    logic               r_neg_y;
    logic [PROD_W-1:0]  r_prod;
    logic [Z_W-1:0]     r_z;
    logic [M_HALF_W-1:0] r_mhi;
    logic [M_W-1:0]     r_lo;
    logic [Q_W-1:0]     r_q;
    logic signed [COORD_W-1:0] r_x;
    t_point             r_pt;
    logic               r_ovalid;

    logic [CNT_W-1:0]   w_m1;
    logic [CNT_W-1:0]   h_m1;
    logic               last_col;
    logic               last_row;
    logic               fend_now;
    logic [PRINC_W-1:0] pos_x16;
    logic [PRINC_W-1:0] pos_y16;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [RECIP_W-1:0] focal_sel;
    logic [39:0]        z_sum;
    logic [M_W+RECIP_W-1:0] q_sum;
    t_point             n_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_depth_scale <= RST_INV_DEPTH_SCALE;
            r_principal_x     <= RST_PRINCIPAL_X;
            r_principal_y     <= RST_PRINCIPAL_Y;
            r_inv_focal_x     <= RST_INV_FOCAL_X;
            r_inv_focal_y     <= RST_INV_FOCAL_Y;
            r_frame_width     <= RST_FRAME_WIDTH;
            r_frame_height    <= RST_FRAME_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INV_DEPTH_SCALE: r_inv_depth_scale <= i_cfg_wr_data[RECIP_W-1:0];
                CFG_PRINCIPAL_X:     r_principal_x     <= i_cfg_wr_data[PRINC_W-1:0];
                CFG_PRINCIPAL_Y:     r_principal_y     <= i_cfg_wr_data[PRINC_W-1:0];
                CFG_INV_FOCAL_X:     r_inv_focal_x     <= i_cfg_wr_data[RECIP_W-1:0];
                CFG_INV_FOCAL_Y:     r_inv_focal_y     <= i_cfg_wr_data[RECIP_W-1:0];
                CFG_FRAME_WIDTH:     r_frame_width     <= i_cfg_wr_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT:    r_frame_height    <= i_cfg_wr_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_m1     = size_m1(r_frame_width, SIZE_W'(MAX_COLS));
    assign h_m1     = size_m1(r_frame_height, SIZE_W'(MAX_ROWS));
    assign last_col = (r_col >= w_m1);
    assign last_row = (r_row >= h_m1);
    assign fend_now = last_col && last_row;
    assign pos_x16  = {r_col, 4'b0000};
    assign pos_y16  = {r_row, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load_in) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + CNT_W'(1);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pix   <= i_pix;
            r_fend  <= fend_now;
            r_neg_x <= (pos_x16 < r_principal_x);
            r_neg_y <= (pos_y16 < r_principal_y);
            r_mag_x <= (pos_x16 < r_principal_x) ? r_principal_x - pos_x16
                                                 : pos_x16 - r_principal_x;
            r_mag_y <= (pos_y16 < r_principal_y) ? r_principal_y - pos_y16
                                                 : pos_y16 - r_principal_y;
        end
    end

    assign focal_sel = i_cmd.axis ? r_inv_focal_y : r_inv_focal_x;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_MAG: begin
                mul_a = r_z;
                mul_b = {{(MUL_B_W-PRINC_W){1'b0}}, i_cmd.axis ? r_mag_y : r_mag_x};
            end
            MS_MLO: begin
                mul_a = {{(MUL_A_W-M_HALF_W){1'b0}}, r_prod[M_HALF_W-1:0]};
                mul_b = focal_sel;
            end
            MS_MHI: begin
                mul_a = {{(MUL_A_W-M_HALF_W){1'b0}}, r_mhi};
                mul_b = focal_sel;
            end
            default: begin
                mul_a = {{(MUL_A_W-DEPTH_W){1'b0}}, r_pix.depth_sample};
                mul_b = r_inv_depth_scale;
            end
        endcase
    end

    assign z_sum = r_prod[39:0] + 40'd128;
    assign q_sum = {r_prod[M_W-1:0], {RECIP_W{1'b0}}}
                 + {{RECIP_W{1'b0}}, r_lo}
                 + (M_W+RECIP_W)'(28'h8000000);

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (i_cmd.cap_z) begin
            r_z <= z_sum[39:8];
        end
        if (i_cmd.cap_mhi) begin
            r_mhi <= r_prod[M_W-1:M_HALF_W];
        end
        if (i_cmd.cap_lo) begin
            r_lo <= r_prod[M_W-1:0];
        end
        if (i_cmd.cap_q) begin
            r_q <= q_sum[M_W+RECIP_W-1:28];
        end
        if (i_cmd.cap_x) begin
            r_x <= apply_sign(r_q, r_neg_x);
        end
    end

    always_comb begin
        if (r_pix.depth_sample == '0) begin
            n_pt = '0;
        end else begin
            n_pt.point_x     = r_x;
            n_pt.point_y     = apply_sign(r_q, r_neg_y);
            n_pt.point_z     = r_z;
            n_pt.point_blue  = r_pix.blue;
            n_pt.point_green = r_pix.green;
            n_pt.point_red   = r_pix.red;
            n_pt.point_valid = 1'b1;
        end
        n_pt.frame_end = r_fend;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_pt <= n_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_pt_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_pt       = r_pt;
    assign o_pt_valid = r_ovalid;

    assign o_sts.depth_zero = (r_pix.depth_sample == '0);
    assign o_sts.frame_end  = r_fend;
    assign o_sts.out_free   = !r_ovalid || !i_pt_stall;

    a_empty_is_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt_valid && !o_pt.point_valid) |-> o_pt.frame_end)
        else $error("An empty result was delivered without the frame-end mark.");

    a_counters_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_in && fend_now) |=> (r_col == '0 && r_row == '0))
        else $error("Pixel counters did not wrap after the last pixel of a frame.");

endmodule

`default_nettype wire

>>> rtl/depth_to_point_backprojection.sv
// Top level of the depth-to-point back-projection block.
// Joins the sequencing controller dtp_ctrl and the datapath dtp_datapath.
// Depends on dtp_pkg.
//
//  Channel   Direction  Handshake                    Payload
//  pixel     in         i_pix_valid / o_pix_stall    i_pix (t_pixel)
//  point     out        o_pt_valid / i_pt_stall      o_pt (t_point)
//  config    in         i_cfg_wr_en                  i_cfg_index, i_cfg_wr_data
//
// A pixel with nonzero depth passes from acceptance through the depth, X and Y steps to the
// output register before the next pixel is accepted, set by the single shared 32x24 multiplier,
// which is used seven times per transaction.
// A zero-depth pixel frees the input after the depth step; at frame end it first emits the mark.
// Reset is synchronous and active low; it restores the register defaults and zeroes the counters.
// The output register holds a result under stall; the controller waits until it is free.
`default_nettype none

module depth_to_point_backprojection import dtp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  wire logic                  i_pix_valid,
    output logic                       o_pix_stall,
    input  wire t_pixel                i_pix,
    output logic                       o_pt_valid,
    input  wire logic                  i_pt_stall,
    output t_point                     o_pt
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dtp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pix         (i_pix),
        .o_pt          (o_pt),
        .o_pt_valid    (o_pt_valid),
        .i_pt_stall    (i_pt_stall),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

`default_nettype wire
